FILE: rtl/csjd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types, constants and register codes of the CAN signal jump detector.
package csjd_pkg;

    localparam int MAX_SIGNAL_BITS_DEFAULT = 32;
    localparam int QUEUE_DEPTH_DEFAULT     = 4;
    localparam int FRAME_BYTES             = 8;
    localparam int DATA_BYTES              = 8;
    localparam int DATA_W                  = DATA_BYTES * 8;
    localparam int BYTE_LIMIT = (FRAME_BYTES < DATA_BYTES) ? FRAME_BYTES : DATA_BYTES;

    localparam int ID_W     = 29;
    localparam int LEN_W    = 6;
    localparam int FLEN_W   = 4;
    localparam int VALUE_W  = 32;
    localparam int CFG_W    = 64;
    localparam int CFG_IDX_W = 3;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_ID     = 3'd0,
        REG_SIGNAL_LAYOUT = 3'd1,
        REG_SCALE_PAIR    = 3'd2,
        REG_VALID_RANGE   = 3'd3,
        REG_JUMP_MODE     = 3'd4,
        REG_FROM_RANGE    = 3'd5,
        REG_TO_RANGE      = 3'd6
    } cfg_index_t;

    typedef enum logic [1:0] {
        MODE_ANY_CHANGE = 2'd0,
        MODE_EXACT      = 2'd1,
        MODE_RANGE      = 2'd2
    } jump_mode_t;

    localparam logic [ID_W-1:0] TARGET_ID_RST     = '0;
    localparam logic [12:0]     SIGNAL_LAYOUT_RST = 13'd512;
    localparam logic [63:0]     SCALE_PAIR_RST    = 64'h0001_0000_0000_0000;
    localparam logic [63:0]     VALID_RANGE_RST   = 64'h8000_0000_7FFF_FFFF;
    localparam logic [1:0]      JUMP_MODE_RST     = 2'd0;
    localparam logic [63:0]     FROM_RANGE_RST    = '0;
    localparam logic [63:0]     TO_RANGE_RST      = '0;

    // Decoded configuration, handed to the front and back ends.
    typedef struct packed {
        logic [ID_W-1:0]           target_id;
        logic [LEN_W-1:0]          field_lsb;
        logic [LEN_W-1:0]          length;
        logic                      sign_flag;
        logic signed [VALUE_W-1:0] factor;
        logic signed [VALUE_W-1:0] offset;
        logic signed [VALUE_W-1:0] min_value;
        logic signed [VALUE_W-1:0] max_value;
        logic [1:0]                mode;
        logic signed [VALUE_W-1:0] from_lo;
        logic signed [VALUE_W-1:0] from_hi;
        logic signed [VALUE_W-1:0] to_lo;
        logic signed [VALUE_W-1:0] to_hi;
    } cfg_t;

endpackage
`default_nettype wire

FILE: rtl/csjd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// Small flip-flop queue between the front and back ends.
module csjd_fifo
    import csjd_pkg::*;
#(
    parameter int WIDTH = 33,
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rd_data,
    output logic                  full,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = slot_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/csjd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// Front end: takes frames, filters on identifier and extracts the raw field.
module csjd_front
    import csjd_pkg::*;
#(
    parameter int MAX_SIGNAL_BITS = MAX_SIGNAL_BITS_DEFAULT
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire cfg_t                         cfg,
    input  wire logic                         frame_valid,
    output logic                              frame_ready,
    input  wire logic [ID_W-1:0]              frame_id,
    input  wire logic [DATA_W-1:0]            frame_data,
    input  wire logic [FLEN_W-1:0]            frame_len,
    output logic                              q_push,
    output logic      [MAX_SIGNAL_BITS:0]     q_raw,
    input  wire logic                         q_full
);

    localparam int RAW_W = MAX_SIGNAL_BITS + 1;

    logic             hold_valid_reg, hold_valid_next;
    logic [RAW_W-1:0] raw_reg;
    logic [RAW_W-1:0] raw_next;
    logic             accept;

    logic [FLEN_W-1:0] nbytes;
    logic [DATA_W-1:0] masked;
    logic [DATA_W-1:0] shifted;
    logic [LEN_W-1:0]  len_eff;
    logic              sign_fill;

    // Bits beyond the frame length read as zero, so the field is cut by a byte mask
    // before the shift; the sign of a cut field therefore comes out as zero.
    always_comb
    begin
        nbytes = (frame_len > FLEN_W'(BYTE_LIMIT)) ? FLEN_W'(BYTE_LIMIT) : frame_len;
        for (int b = 0; b < DATA_BYTES; b++)
        begin
            masked[b*8 +: 8] = (FLEN_W'(b) < nbytes) ? frame_data[b*8 +: 8] : 8'h00;
        end
        shifted = masked >> cfg.field_lsb;
        len_eff = (cfg.length > LEN_W'(MAX_SIGNAL_BITS)) ? LEN_W'(MAX_SIGNAL_BITS)
                                                          : cfg.length;
        sign_fill = 1'b0;
        for (int i = 0; i < MAX_SIGNAL_BITS; i++)
        begin
            if (len_eff == LEN_W'(i + 1))
            begin
                sign_fill = cfg.sign_flag & shifted[i];
            end
        end
        for (int i = 0; i < MAX_SIGNAL_BITS; i++)
        begin
            raw_next[i] = (LEN_W'(i) < len_eff) ? shifted[i] : sign_fill;
        end
        raw_next[RAW_W-1] = sign_fill;
    end

    assign q_push      = hold_valid_reg && !q_full;
    assign frame_ready = !hold_valid_reg || !q_full;
    assign accept      = frame_valid && frame_ready;
    assign q_raw       = raw_reg;

    always_comb
    begin
        if (accept)
        begin
            hold_valid_next = (frame_id == cfg.target_id);
        end
        else
        begin
            hold_valid_next = hold_valid_reg && !q_push;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            raw_reg <= raw_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/csjd_back.sv
`timescale 1ns / 1ps
`default_nettype none
// Back end: scaling, saturation, range check, jump test and result register.
module csjd_back
    import csjd_pkg::*;
#(
    parameter int MAX_SIGNAL_BITS = MAX_SIGNAL_BITS_DEFAULT
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire cfg_t                      cfg,
    input  wire logic                      q_empty,
    output logic                           q_pop,
    input  wire logic [MAX_SIGNAL_BITS:0]  q_raw,
    output logic                           jump_valid,
    input  wire logic                      jump_ready,
    output logic signed [VALUE_W-1:0]      prev_value,
    output logic signed [VALUE_W-1:0]      curr_value
);

    localparam int RAW_W  = MAX_SIGNAL_BITS + 1;
    localparam int PROD_W = RAW_W + VALUE_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int HI_W   = SUM_W - (VALUE_W - 1);

    function automatic logic in_span(input logic signed [VALUE_W-1:0] v,
                                     input logic signed [VALUE_W-1:0] lo,
                                     input logic signed [VALUE_W-1:0] hi);
        return (v >= lo) && (v <= hi);
    endfunction

    logic                      advance;

    // multiply stage
    logic                      mul_valid_reg, mul_valid_next;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [PROD_W-1:0]  raw_ext;
    logic signed [PROD_W-1:0]  factor_ext;

    // offset, saturation and valid range stage
    logic                      sat_valid_reg, sat_valid_next;
    logic signed [VALUE_W-1:0] sat_reg;
    logic signed [VALUE_W-1:0] sat_next;
    logic signed [SUM_W-1:0]   sum;
    logic        [HI_W-1:0]    sum_top;

    // stored value and jump test
    logic                      seen_reg, seen_next;
    logic signed [VALUE_W-1:0] last_reg, last_next;
    logic                      hit;

    logic                      out_valid_reg, out_valid_next;
    logic signed [VALUE_W-1:0] prev_reg;
    logic signed [VALUE_W-1:0] curr_reg;

    // The whole back pipeline moves together whenever the result register is free.
    assign advance = !out_valid_reg || jump_ready;
    assign q_pop   = advance && !q_empty;

    assign raw_ext    = PROD_W'($signed(q_raw));
    assign factor_ext = PROD_W'(cfg.factor);
    assign prod_next  = raw_ext * factor_ext;

    always_comb
    begin
        sum     = SUM_W'(prod_reg) + SUM_W'(cfg.offset);
        sum_top = sum[SUM_W-1:VALUE_W-1];
        if ((&sum_top) || !(|sum_top))
        begin
            sat_next = sum[VALUE_W-1:0];
        end
        else if (sum[SUM_W-1])
        begin
            sat_next = {1'b1, {(VALUE_W - 1){1'b0}}};
        end
        else
        begin
            sat_next = {1'b0, {(VALUE_W - 1){1'b1}}};
        end
    end

    always_comb
    begin
        mul_valid_next = mul_valid_reg;
        sat_valid_next = sat_valid_reg;
        if (advance)
        begin
            mul_valid_next = q_pop;
            sat_valid_next = mul_valid_reg && in_span(sat_next, cfg.min_value, cfg.max_value);
        end
    end

    always_comb
    begin
        case (cfg.mode)
            MODE_ANY_CHANGE: hit = (last_reg != sat_reg);
            MODE_EXACT:      hit = (last_reg == cfg.from_lo) && (sat_reg == cfg.to_lo);
            MODE_RANGE:      hit = in_span(last_reg, cfg.from_lo, cfg.from_hi)
                                   && in_span(sat_reg, cfg.to_lo, cfg.to_hi);
            default:         hit = 1'b0;
        endcase
        hit = hit && seen_reg && sat_valid_reg;
    end

    always_comb
    begin
        seen_next      = seen_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = hit;
            if (sat_valid_reg)
            begin
                seen_next = 1'b1;
                last_next = sat_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            sat_valid_reg <= 1'b0;
            seen_reg      <= 1'b0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mul_valid_reg <= mul_valid_next;
            sat_valid_reg <= sat_valid_next;
            seen_reg      <= seen_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            prod_reg <= prod_next;
        end
        if (advance && mul_valid_reg)
        begin
            sat_reg <= sat_next;
        end
        if (advance && hit)
        begin
            prev_reg <= last_reg;
            curr_reg <= sat_reg;
        end
    end

    assign jump_valid = out_valid_reg;
    assign prev_value = prev_reg;
    assign curr_value = curr_reg;

endmodule
`default_nettype wire

FILE: rtl/can_signal_jump_detector.sv
`timescale 1ns / 1ps
`default_nettype none
// CAN signal jump detector: watches one signal of one CAN identifier and
// reports a beat whenever the scaled value jumps as configured.
//
// Input channel (frame_valid / frame_ready): one beat is one received frame.
// Frames of another identifier are taken and discarded. The front end holds one
// frame, extracts the raw field and hands it to a four-entry queue; the back end
// scales it (one 33 x 32 bit multiply), adds the offset, saturates, checks the
// valid range and compares against the stored value.
// Output channel (jump_valid / jump_ready): one beat carries the previous and the
// current value of a detected jump. A frame passes the front holding register, the
// queue, the product, saturated-value and result registers. One frame per cycle is
// sustained while the receiver takes results. Configuration is written through
// cfg_we / cfg_index / cfg_data; the user must do so only while no frame is in
// flight, which the block does not enforce; indexes beyond the register list are ignored.
// Reset clears the registers to their documented values, forgets the stored value
// and empties the pipeline. When the receiver stalls, the result stays on the
// output, the back end freezes, and frames keep being taken until the queue and
// the front stage are full.
module can_signal_jump_detector
    import csjd_pkg::*;
#(
    parameter int MAX_SIGNAL_BITS = MAX_SIGNAL_BITS_DEFAULT,
    parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [CFG_W-1:0]          cfg_data,
    input  wire logic                      frame_valid,
    output logic                           frame_ready,
    input  wire logic [ID_W-1:0]           frame_id,
    input  wire logic [DATA_W-1:0]         frame_data,
    input  wire logic [FLEN_W-1:0]         frame_len,
    output logic                           jump_valid,
    input  wire logic                      jump_ready,
    output logic signed [VALUE_W-1:0]      prev_value,
    output logic signed [VALUE_W-1:0]      curr_value
);

    localparam int RAW_W = MAX_SIGNAL_BITS + 1;

    logic [ID_W-1:0] target_id_reg;
    logic [12:0]     signal_layout_reg;
    logic [63:0]     scale_pair_reg;
    logic [63:0]     valid_range_reg;
    logic [1:0]      jump_mode_reg;
    logic [63:0]     from_range_reg;
    logic [63:0]     to_range_reg;
    cfg_t            cfg;

    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    logic [RAW_W-1:0] q_wr_raw;
    logic [RAW_W-1:0] q_rd_raw;

    // Register file. Only the low bits of each write that the register holds are kept.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_id_reg     <= TARGET_ID_RST;
            signal_layout_reg <= SIGNAL_LAYOUT_RST;
            scale_pair_reg    <= SCALE_PAIR_RST;
            valid_range_reg   <= VALID_RANGE_RST;
            jump_mode_reg     <= JUMP_MODE_RST;
            from_range_reg    <= FROM_RANGE_RST;
            to_range_reg      <= TO_RANGE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TARGET_ID:     target_id_reg     <= cfg_data[ID_W-1:0];
                REG_SIGNAL_LAYOUT: signal_layout_reg <= cfg_data[12:0];
                REG_SCALE_PAIR:    scale_pair_reg    <= cfg_data;
                REG_VALID_RANGE:   valid_range_reg   <= cfg_data;
                REG_JUMP_MODE:     jump_mode_reg     <= cfg_data[1:0];
                REG_FROM_RANGE:    from_range_reg    <= cfg_data;
                REG_TO_RANGE:      to_range_reg      <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Split the packed registers into their named fields.
    always_comb
    begin
        cfg.target_id = target_id_reg;
        cfg.field_lsb = signal_layout_reg[5:0];
        cfg.length    = signal_layout_reg[11:6];
        cfg.sign_flag = signal_layout_reg[12];
        cfg.factor    = scale_pair_reg[63:32];
        cfg.offset    = scale_pair_reg[31:0];
        cfg.min_value = valid_range_reg[63:32];
        cfg.max_value = valid_range_reg[31:0];
        cfg.mode      = jump_mode_reg;
        cfg.from_lo   = from_range_reg[63:32];
        cfg.from_hi   = from_range_reg[31:0];
        cfg.to_lo     = to_range_reg[63:32];
        cfg.to_hi     = to_range_reg[31:0];
    end

    csjd_front #(
        .MAX_SIGNAL_BITS(MAX_SIGNAL_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame_id    (frame_id),
        .frame_data  (frame_data),
        .frame_len   (frame_len),
        .q_push      (q_push),
        .q_raw       (q_wr_raw),
        .q_full      (q_full)
    );

    csjd_fifo #(
        .WIDTH(RAW_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr_raw),
        .pop     (q_pop),
        .rd_data (q_rd_raw),
        .full    (q_full),
        .empty   (q_empty)
    );

    csjd_back #(
        .MAX_SIGNAL_BITS(MAX_SIGNAL_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .q_raw      (q_rd_raw),
        .jump_valid (jump_valid),
        .jump_ready (jump_ready),
        .prev_value (prev_value),
        .curr_value (curr_value)
    );

endmodule
`default_nettype wire

FILE: rtl/csjd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// Port-level checker of the CAN signal jump detector and its bind statement.
module csjd_checker
    import csjd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data,
    input  wire logic                  jump_valid,
    input  wire logic                  jump_ready,
    input  wire logic [VALUE_W-1:0]    prev_value,
    input  wire logic [VALUE_W-1:0]    curr_value
);

    // Shadow copies of the mode and the low bounds, taken from the write port.
    logic [1:0]         mode_reg;
    logic [VALUE_W-1:0] from_lo_reg;
    logic [VALUE_W-1:0] to_lo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= JUMP_MODE_RST;
            from_lo_reg <= FROM_RANGE_RST[63:32];
            to_lo_reg   <= TO_RANGE_RST[63:32];
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_JUMP_MODE)
            begin
                mode_reg <= cfg_data[1:0];
            end
            if (cfg_index == REG_FROM_RANGE)
            begin
                from_lo_reg <= cfg_data[63:32];
            end
            if (cfg_index == REG_TO_RANGE)
            begin
                to_lo_reg <= cfg_data[63:32];
            end
        end
    end

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        jump_valid && !jump_ready |=> jump_valid && $stable(prev_value) && $stable(curr_value))
        else $error("result beat changed while stalled");

    a_quiet_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !jump_valid)
        else $error("result beat straight after reset");

    a_any_change_differs: assert property (@(posedge clk) disable iff (!rst_n)
        jump_valid && (mode_reg == MODE_ANY_CHANGE) |-> prev_value != curr_value)
        else $error("change reported without a change");

    a_exact_matches: assert property (@(posedge clk) disable iff (!rst_n)
        jump_valid && (mode_reg == MODE_EXACT)
        |-> (prev_value == from_lo_reg) && (curr_value == to_lo_reg))
        else $error("exact jump reported with other values");

    a_unused_mode_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg != MODE_ANY_CHANGE) && (mode_reg != MODE_EXACT)
        && (mode_reg != MODE_RANGE) |-> !jump_valid)
        else $error("result beat in the unused mode");

endmodule

bind can_signal_jump_detector csjd_checker u_csjd_checker (.*);
`default_nettype wire
